FILE: hdl/maf_pkg.sv
// ============================================================================
// maf_pkg
// Shared types and fixed constants of the moving average filter: controller
// states, the command and status groups between controller and datapath, and
// the configuration register map.
// ============================================================================
package maf_pkg;

    // Fixed field widths of the result item and the configuration registers.
    localparam int AVG_W      = 24;
    localparam int DIV_W      = 5;
    localparam int WLEN_W     = 5;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register selects, taken from address bit 2 (registers at 4-byte spacing).
    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic REG_TAIL_MODE     = 1'b1;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_START,
        ST_DIV
    } maf_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // take the input item, write it to the store
        logic sum_run;    // step the window sum
        logic div_start;  // start a division, fetch the oldest sample of the window
        logic out_load;   // move the quotient into the output register
        logic tail_step;  // drop the oldest sample, shrink the divisor
    } maf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit_any;   // the item on the input causes at least one result
        logic sum_done;   // the window sum is complete
        logic div_done;   // the quotient is ready
        logic more;       // further end windows follow the current result
    } maf_sts_t;

endpackage

FILE: hdl/maf_if.sv
// ============================================================================
// maf_if
// Valid/ready channels of the moving average filter: the sample channel and
// the result channel.
// ============================================================================
interface maf_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   stream_end;

    modport source (output valid, output sample, output stream_end, input ready);
    modport sink   (input valid, input sample, input stream_end, output ready);
endinterface

interface maf_result_if;
    logic                        valid;
    logic                        ready;
    logic [maf_pkg::AVG_W-1:0]   average;
    logic [maf_pkg::DIV_W-1:0]   divisor_used;
    logic                        last_result;

    modport source (output valid, output average, output divisor_used,
                    output last_result, input ready);
    modport sink   (input valid, input average, input divisor_used,
                    input last_result, output ready);
endinterface

FILE: hdl/maf_ram.sv
// ============================================================================
// maf_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module maf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/maf_div.sv
// ============================================================================
// maf_div
// Restoring divider, one quotient bit per cycle. The quotient holds until
// the next start.
// ============================================================================
module maf_div #(
    parameter int DIVIDEND_W = 28,
    parameter int DIVISOR_W  = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic                  done
);

    localparam int CW = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = done_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CW'(DIVIDEND_W);
            done_next = 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            // Remainder stays below the divisor, so the trial fits one extra bit.
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - CW'(1);
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

FILE: hdl/maf_datapath.sv
// ============================================================================
// maf_datapath
// Window store, stream pointers, window sum accumulator, divider and the
// output register of the moving average filter.
// ============================================================================
module maf_datapath #(
    parameter int MAX_WINDOW    = 16,
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  maf_pkg::maf_cmd_t             cmd,
    output maf_pkg::maf_sts_t             sts,
    input  logic [SAMPLE_BITS-1:0]        sample,
    input  logic                          stream_end,
    input  logic [maf_pkg::WLEN_W-1:0]    window_length,
    input  logic                          tail_mode,
    output logic [maf_pkg::AVG_W-1:0]     average,
    output logic [maf_pkg::DIV_W-1:0]     divisor_used,
    output logic                          last_result
);

    localparam int ADDR_W = $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int Q_W    = SUM_W + FRACTION_BITS;
    localparam int CMP_W  = (CNT_W > maf_pkg::WLEN_W) ? CNT_W : maf_pkg::WLEN_W;
    localparam logic [ADDR_W+1:0] MAX_X = (ADDR_W + 2)'(MAX_WINDOW);
    localparam logic [CNT_W-1:0]  MAX_C = CNT_W'(MAX_WINDOW);

    // Store slot that lies off places behind base, modulo the store depth.
    function automatic logic [ADDR_W-1:0] slot_back(input logic [ADDR_W-1:0] base,
                                                    input logic [CNT_W-1:0]  off);
        logic [ADDR_W+1:0] t;
        t = {2'b00, base} + MAX_X - (ADDR_W + 2)'(off);
        if (t >= MAX_X)
        begin
            t = t - MAX_X;
        end
        return t[ADDR_W-1:0];
    endfunction

    logic [ADDR_W-1:0]      wp_reg, wp_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [ADDR_W-1:0]      base_reg;
    logic [CNT_W-1:0]       avail_reg;
    logic [CNT_W-1:0]       issued_reg;
    logic                   rvalid_reg;
    logic [SUM_W-1:0]       acc_reg;
    logic [CNT_W-1:0]       k_reg;
    logic                   tail_on_reg;
    logic [maf_pkg::AVG_W-1:0] avg_reg;
    logic [maf_pkg::DIV_W-1:0] dvu_reg;
    logic                   last_reg;

    logic [ADDR_W-1:0]      wp_inc;
    logic [CNT_W-1:0]       len;
    logic [CNT_W-1:0]       avail;
    logic [CMP_W-1:0]       wl_x;
    logic                   issue;
    logic                   re;
    logic [ADDR_W-1:0]      raddr;
    logic [SAMPLE_BITS-1:0] rdata;
    logic [Q_W-1:0]         dividend;
    logic [Q_W-1:0]         quotient;
    logic                   div_done;
    logic [Q_W+maf_pkg::AVG_W-1:0]   q_ext;
    logic [CNT_W+maf_pkg::DIV_W-1:0] k_ext;

    // Active length: zero counts as one, anything above the store depth saturates.
    assign wl_x = CMP_W'(window_length);
    always_comb
    begin
        priority if (window_length == '0)
        begin
            len = CNT_W'(1);
        end
        else if (wl_x > CMP_W'(MAX_WINDOW))
        begin
            len = MAX_C;
        end
        else
        begin
            len = wl_x[CNT_W-1:0];
        end
    end

    assign wp_inc    = (wp_reg == ADDR_W'(MAX_WINDOW - 1)) ? '0 : wp_reg + ADDR_W'(1);
    assign fill_next = (fill_reg == MAX_C) ? MAX_C : fill_reg + CNT_W'(1);
    assign avail     = (fill_next < len) ? fill_next : len;

    assign sts.emit_any = (tail_mode && stream_end) || (fill_next >= len);

    // Window sum: read the newest avail samples one per cycle from the registered port.
    assign issue        = cmd.sum_run && (issued_reg != avail_reg);
    assign sts.sum_done = (issued_reg == avail_reg) && !rvalid_reg;
    assign sts.more     = tail_on_reg && (k_reg > CNT_W'(1));

    // At division start the oldest sample of the current window is fetched; it stays
    // in the read register for the shrink step that follows.
    assign re    = issue || cmd.div_start;
    assign raddr = cmd.div_start ? slot_back(base_reg, k_reg)
                                 : slot_back(base_reg, issued_reg + CNT_W'(1));

    maf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (wp_reg),
        .wdata (sample),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign dividend = Q_W'(acc_reg) << FRACTION_BITS;

    maf_div #(
        .DIVIDEND_W (Q_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (k_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    assign sts.div_done = div_done;

    always_comb
    begin
        wp_next = wp_reg;
        if (cmd.load)
        begin
            wp_next = stream_end ? '0 : wp_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            fill_reg   <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            wp_reg     <= wp_next;
            rvalid_reg <= issue;
            if (cmd.load)
            begin
                fill_reg <= stream_end ? '0 : fill_next;
            end
        end
    end

    assign q_ext = {{maf_pkg::AVG_W{1'b0}}, quotient};
    assign k_ext = {{maf_pkg::DIV_W{1'b0}}, k_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg    <= wp_inc;
            avail_reg   <= avail;
            k_reg       <= avail;
            tail_on_reg <= tail_mode && stream_end;
            issued_reg  <= '0;
            acc_reg     <= '0;
        end
        else
        begin
            if (issue)
            begin
                issued_reg <= issued_reg + CNT_W'(1);
            end
            if (cmd.sum_run && rvalid_reg)
            begin
                acc_reg <= acc_reg + SUM_W'(rdata);
            end
            if (cmd.tail_step)
            begin
                acc_reg <= acc_reg - SUM_W'(rdata);
                k_reg   <= k_reg - CNT_W'(1);
            end
        end
        if (cmd.out_load)
        begin
            avg_reg  <= q_ext[maf_pkg::AVG_W-1:0];
            dvu_reg  <= k_ext[maf_pkg::DIV_W-1:0];
            last_reg <= !sts.more;
        end
    end

    assign average      = avg_reg;
    assign divisor_used = dvu_reg;
    assign last_result  = last_reg;

endmodule

FILE: hdl/maf_ctrl.sv
// ============================================================================
// maf_ctrl
// Controller of the moving average filter: sequences load, window sum,
// division and result hand-off, and owns both handshakes.
// ============================================================================
module maf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output maf_pkg::maf_cmd_t cmd,
    input  maf_pkg::maf_sts_t sts
);

    maf_pkg::maf_state_t state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_free;

    // The output register can take a new result once the old one leaves.
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= maf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            maf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.emit_any)
                    begin
                        state_next = maf_pkg::ST_SUM;
                    end
                end
            end
            maf_pkg::ST_SUM:
            begin
                cmd.sum_run = 1'b1;
                if (sts.sum_done)
                begin
                    state_next = maf_pkg::ST_START;
                end
            end
            maf_pkg::ST_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = maf_pkg::ST_DIV;
            end
            maf_pkg::ST_DIV:
            begin
                if (sts.div_done && out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    if (sts.more)
                    begin
                        cmd.tail_step = 1'b1;
                        state_next    = maf_pkg::ST_START;
                    end
                    else
                    begin
                        state_next = maf_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = maf_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: hdl/moving_average_filter.sv
// ============================================================================
// moving_average_filter
// Boxcar moving average over a stream of unsigned samples, with optional
// shrinking end windows when a stream ends.
// ============================================================================
// An item's first result sums its newest avail samples through the single read port,
// later ones drop the oldest sample; the sum is then divided over Q = SAMPLE_BITS +
// clog2(MAX_WINDOW) + FRACTION_BITS quotient bits (28 at the defaults) in a
// one-bit-per-cycle divider. Items without a result are taken one per cycle; after
// an item with results, the next is taken once its last result is loaded for output.
// Reset: asynchronous, active low; restores window_length 3 and tail_mode 0.
// ============================================================================
module moving_average_filter #(
    parameter int MAX_WINDOW    = 16,
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    maf_sample_if.sink                      sample_ch,
    maf_result_if.source                    result_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [maf_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [maf_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [maf_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    // ------------------------------------------------------------------------
    // Configuration registers. Software must write them only while the filter is
    // idle; the block does not enforce this. The datapath reads them directly
    // without any shadow copy. Address bit 2 selects the register; the low address
    // bits are ignored. The stream state is cleared by reset; the store is not.
    // ------------------------------------------------------------------------
    logic [maf_pkg::WLEN_W-1:0] wlen_reg;
    logic                       tail_reg;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= maf_pkg::WLEN_RESET;
            tail_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                maf_pkg::REG_WINDOW_LENGTH: wlen_reg <= pwdata[maf_pkg::WLEN_W-1:0];
                maf_pkg::REG_TAIL_MODE:     tail_reg <= pwdata[0];
                default:                    wlen_reg <= wlen_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            maf_pkg::REG_WINDOW_LENGTH:
                prdata = maf_pkg::APB_DATA_W'(wlen_reg);
            maf_pkg::REG_TAIL_MODE:
                prdata = maf_pkg::APB_DATA_W'(tail_reg);
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Controller and datapath. The controller owns the handshakes: it takes an
    // item only from its idle state, though a finished result may still be
    // waiting in the output register at that time. A new result is loaded only
    // once the previous one has been taken, so nothing is overwritten.
    // ------------------------------------------------------------------------
    maf_pkg::maf_cmd_t cmd;
    maf_pkg::maf_sts_t sts;
    logic              in_ready;
    logic              out_valid;

    maf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_ch.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    assign sample_ch.ready = in_ready;
    assign result_ch.valid = out_valid;

    // The datapath writes each sample into the circular store, sums the newest
    // window by reading the store one entry per cycle, and divides the sum by
    // its element count. For the end windows of a stream, each smaller window
    // sum comes from the previous one by removing its oldest sample.
    maf_datapath #(
        .MAX_WINDOW    (MAX_WINDOW),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .sample        (sample_ch.sample),
        .stream_end    (sample_ch.stream_end),
        .window_length (wlen_reg),
        .tail_mode     (tail_reg),
        .average       (result_ch.average),
        .divisor_used  (result_ch.divisor_used),
        .last_result   (result_ch.last_result)
    );

endmodule
